@@ sv/skst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_pkg
// Shared types and constants for the sorted keyed score table.
// ----------------------------------------------------------------------------
package skst_pkg;

	localparam int NAME_W     = 64;
	localparam int SCORE_W    = 24;
	localparam int RANK_W     = 5;
	localparam int NAME_CHARS = 8;
	localparam int DEPTH_DEF  = 16;
	localparam int ENTRY_W    = NAME_W + SCORE_W;

	typedef struct packed {
		logic [NAME_W-1:0]         name;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LIST
	} state_t;

endpackage

@@ sv/sorted_keyed_score_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyed_score_table_core
// Ranked table of up to DEPTH (name, score) entries with upsert and full listing.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The block then
// walks the stored table once through the single RAM read port to find a
// matching name and the insertion rank, and walks it a second time to write
// the updated table into the other half of a ping-pong RAM while streaming
// every entry out in rank order, one per cycle, each marked by valid for a
// single cycle; the receiver cannot stall the stream. Busy stays high from
// the accepted start through the listing, and the final result, marked by
// last, appears in the last cycle of busy. The next start is taken in the
// first cycle after busy falls.
// ----------------------------------------------------------------------------
module sorted_keyed_score_table_core
	import skst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [NAME_W-1:0]         key_name,
	input  logic signed [SCORE_W-1:0] new_score,
	output logic                      valid,
	output logic [RANK_W-1:0]         rank,
	output logic [NAME_W-1:0]         entry_name,
	output logic signed [SCORE_W-1:0] entry_score,
	output logic                      dropped,
	output logic                      last
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int ADDR_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	state_t state_q, state_n;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [NAME_W-1:0]        key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                     found_q;
	logic [IDX_W-1:0]         match_q;
	logic [CNT_W-1:0]         pos_q;
	logic [CNT_W-1:0]         newcnt_q;
	logic                     dropped_q;
	logic                     bank_q;

	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     sel_new_s1;

	logic                     valid_q;
	logic [RANK_W-1:0]        rank_q;
	logic [NAME_W-1:0]        name_q;
	logic signed [SCORE_W-1:0] oscore_q;
	logic                     last_q;

	logic [NAME_W-1:0]        canon_name;
	logic                     accept;
	logic                     issue;
	logic                     scan_done;
	logic                     list_done;
	logic [CNT_W-1:0]         limit;
	logic                     pos_hit;
	logic [CNT_W-1:0]         rel_idx;
	logic [CNT_W-1:0]         src_idx;
	logic [ADDR_W-1:0]        raddr;
	logic [ENTRY_W-1:0]       rdata;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	entry_t                   rd_entry;
	entry_t                   wr_entry;
	logic                     found_n;
	logic                     dropped_n;
	logic [CNT_W-1:0]         newcnt_n;

	always_comb begin
		logic alive;
		logic [7:0] b;
		alive = 1'b1;
		canon_name = '0;
		for (int i = 0; i < NAME_W / 8; i++) begin
			b = key_name[NAME_W-1-8*i -: 8];
			alive = alive && (b != 8'd0) && (i < NAME_CHARS);
			canon_name[NAME_W-1-8*i -: 8] = alive ? b : 8'd0;
		end
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		busy = (state_q != ST_IDLE);
		limit = (state_q == ST_SCAN) ? count_q : newcnt_q;
		issue = (state_q != ST_IDLE) && (cnt_q < limit);
		scan_done = (state_q == ST_SCAN) && (cnt_q == count_q) && !vld_s1;
		list_done = (state_q == ST_LIST) && (cnt_q == newcnt_q) && !vld_s1;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_n = ST_LIST;
				end
			end
			ST_LIST: begin
				if (list_done) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pos_hit = !dropped_q && (cnt_q == pos_q);
		rel_idx = (!dropped_q && (cnt_q > pos_q)) ? cnt_q - CNT_W'(1) : cnt_q;
		src_idx = (found_q && (rel_idx >= CNT_W'(match_q))) ? rel_idx + CNT_W'(1) : rel_idx;
		if (state_q == ST_SCAN) begin
			raddr = {bank_q, cnt_q[IDX_W-1:0]};
		end else begin
			raddr = {bank_q, src_idx[IDX_W-1:0]};
		end
	end

	always_comb begin
		found_n   = found_q;
		dropped_n = !found_q && (count_q == DEPTH_C) && (pos_q == count_q);
		if (found_q || (count_q == DEPTH_C)) begin
			newcnt_n = count_q;
		end else begin
			newcnt_n = count_q + CNT_W'(1);
		end
	end

	assign rd_entry = entry_t'(rdata);

	always_comb begin
		if (sel_new_s1) begin
			wr_entry.name  = key_q;
			wr_entry.score = score_q;
		end else begin
			wr_entry = rd_entry;
		end
	end

	assign we    = vld_s1 && (state_q == ST_LIST);
	assign waddr = {~bank_q, idx_s1};

	skst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(2 ** ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			match_q   <= '0;
			pos_q     <= '0;
			newcnt_q  <= '0;
			dropped_q <= 1'b0;
			bank_q    <= 1'b0;
			vld_s1    <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			vld_s1  <= issue;
			valid_q <= we;
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				pos_q   <= '0;
			end else if (scan_done) begin
				cnt_q     <= '0;
				found_q   <= found_n;
				newcnt_q  <= newcnt_n;
				dropped_q <= dropped_n;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (vld_s1 && (state_q == ST_SCAN)) begin
				if (rd_entry.name == key_q) begin
					found_q <= 1'b1;
					match_q <= idx_s1;
				end else if (rd_entry.score >= score_q) begin
					pos_q <= pos_q + CNT_W'(1);
				end
			end
			if (list_done) begin
				bank_q  <= ~bank_q;
				count_q <= newcnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= canon_name;
			score_q <= new_score;
		end
		idx_s1     <= cnt_q[IDX_W-1:0];
		sel_new_s1 <= (state_q == ST_LIST) && pos_hit;
		if (we) begin
			rank_q   <= RANK_W'(CNT_W'(idx_s1) + CNT_W'(1));
			name_q   <= wr_entry.name;
			oscore_q <= wr_entry.score;
			last_q   <= (CNT_W'(idx_s1) + CNT_W'(1)) == newcnt_q;
		end
	end

	assign valid       = valid_q;
	assign rank        = rank_q;
	assign entry_name  = name_q;
	assign entry_score = oscore_q;
	assign dropped     = dropped_q;
	assign last        = last_q;

endmodule

@@ sv/skst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/skst_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_chk
// Port-level checks on the ranked listing stream of the score table.
// ----------------------------------------------------------------------------
module skst_chk
	import skst_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      valid,
	input logic [RANK_W-1:0]         rank,
	input logic                      dropped,
	input logic                      last
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	a_first_rank: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !$past(valid) |-> rank == RANK_W'(1))
		else $error("listing does not open at rank 1");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid && rank == RANK_W'($past(rank) + RANK_W'(1))
			&& dropped == $past(dropped))
		else $error("listing broken before its last result");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("result right after the last one of a listing");

endmodule

bind sorted_keyed_score_table_core skst_chk u_skst_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.rank   (rank),
	.dropped(dropped),
	.last   (last)
);
